FILE: rtl/ptd_pkg.sv
`default_nettype none
package ptd_pkg;
	localparam int SLOTS = 16;
	localparam int SW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);

	localparam logic [1:0] CMD_CREATE   = 2'd0;
	localparam logic [1:0] CMD_DELETE   = 2'd1;
	localparam logic [1:0] CMD_TICK     = 2'd2;
	localparam logic [1:0] CMD_DISPATCH = 2'd3;

	localparam logic [2:0] KIND_CREATE = 3'd0;
	localparam logic [2:0] KIND_DELETE = 3'd1;
	localparam logic [2:0] KIND_TICK   = 3'd2;
	localparam logic [2:0] KIND_DUE    = 3'd3;
	localparam logic [2:0] KIND_END    = 3'd4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  task_id;
		logic [15:0] period;
		logic [7:0]  priority_req;
		logic [3:0]  slot;
	} cmd_word_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic        ok;
		logic [3:0]  handle;
		logic [7:0]  due_task;
		logic [15:0] elapsed_period;
		logic        last;
	} res_word_t;

	// order entry held in one cell of the chain
	typedef struct packed {
		logic          valid;
		logic [SW-1:0] slot;
		logic [7:0]    prio;
	} entry_t;

	// control broadcast from the sequencer to every cell
	typedef enum logic [2:0] {
		OP_HOLD   = 3'b001,
		OP_INSERT = 3'b010,
		OP_REMOVE = 3'b100
	} cell_op_t;

	typedef struct packed {
		cell_op_t      op;
		logic [SW-1:0] slot;
		logic [7:0]    prio;
		logic          rotate;
	} cell_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/periodic_task_dispatcher.sv
`default_nettype none
// Periodic task dispatcher. Issue a command word with start while busy is low;
// results appear on res, each flagged by res_valid for one cycle, and must be
// taken as they come: there is no back-pressure. Create, delete and tick hold
// busy for one cycle and give their one word in the cycle after, and a new such
// command is taken only once busy is low again. Dispatch circulates the dispatch
// order, held in a chain of SLOTS cells, past the head once, one entry at a time
// (latch the head and its slot data, then check it): busy stays high through
// the walk, due words come as due entries are checked and the end marker
// follows in the first idle cycle. The slot tables are small memories read
// one slot per cycle.
module periodic_task_dispatcher (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire ptd_pkg::cmd_word_t  cmd,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [7:0]          cfg_data,
	output logic                     res_valid,
	output ptd_pkg::res_word_t       res
);
	import ptd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_WALK = 5'b00100,
		ST_DUE  = 5'b01000,
		ST_END  = 5'b10000
	} state_t;

	state_t         state_q, state_d;
	cmd_word_t      c_q, c_d;
	logic [7:0]     maxp_q, maxp_d;
	logic [31:0]    now_q, now_d;
	logic [SLOTS-1:0] used_q, used_d;
	logic [LW-1:0]  cnt_q, cnt_d;
	logic [LW-1:0]  len_q, len_d;
	logic           res_valid_d;
	res_word_t      res_d;

	logic [7:0]     task_m [SLOTS];
	logic [15:0]    per_m  [SLOTS];
	logic [31:0]    run_m  [SLOTS];

	cell_ctl_t      ctl;
	entry_t         cells [SLOTS];
	logic           ins   [SLOTS];
	logic           rem   [SLOTS];
	logic           shift_in [SLOTS];
	entry_t         empty_e;

	logic [SW-1:0]  free_slot;
	logic           have_free;
	logic           create_ok, delete_ok;
	logic           wr_slot;
	logic           rem_any;
	logic           due_hit;

	// head entry read registered for the due check
	entry_t         head_s1;
	logic [7:0]     task_s1;
	logic [15:0]    per_s1;
	logic [31:0]    run_s1;

	assign empty_e   = '0;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	// lowest free slot
	always_comb begin
		free_slot = '0;
		have_free = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_slot = SW'(i);
				have_free = 1'b1;
			end
		end
	end

	assign create_ok = (c_q.task_id != 8'd0) && (c_q.period != 16'd0) &&
		(c_q.priority_req <= maxp_q) && have_free;
	assign delete_ok = used_q[c_q.slot[SW-1:0]];
	assign due_hit   = head_s1.valid && ((now_q - run_s1) >= {16'd0, per_s1});

	always_comb begin
		rem_any = 1'b0;
		for (int i = 0; i < SLOTS; i++) rem_any = rem_any | rem[i];
	end

	// broadcast control to the chain
	always_comb begin
		ctl.op     = OP_HOLD;
		ctl.slot   = free_slot;
		ctl.prio   = c_q.priority_req;
		ctl.rotate = 1'b0;
		if (state_q == ST_EXEC) begin
			case (c_q.cmd)
				CMD_CREATE: if (create_ok) ctl.op = OP_INSERT;
				CMD_DELETE: begin
					ctl.slot = c_q.slot[SW-1:0];
					if (delete_ok) ctl.op = OP_REMOVE;
				end
				default: ;
			endcase
		end
		if (state_q == ST_WALK && cnt_q != '0) ctl.rotate = 1'b1;
	end

	// chain of cells; remove shifts up from the matching cell, carried on shift_in
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		logic   p_flag;
		entry_t p_e, n_e;
		if (g == 0) begin : g_head
			assign p_e = empty_e;
			assign p_flag = 1'b0;
		end else begin : g_body
			assign p_e = cells[g-1];
			assign p_flag = (ctl.op == OP_REMOVE) ? shift_in[g-1] : ins[g-1];
		end
		if (g == SLOTS - 1) begin : g_tail
			assign n_e = (ctl.rotate) ? cells[0] : empty_e;
		end else begin : g_mid
			assign n_e = cells[g+1];
		end
		assign shift_in[g] = (ctl.op == OP_REMOVE) ? (p_flag || rem[g]) : p_flag;
		ptd_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.prev(p_e), .next(n_e), .prev_ins(shift_in[g]),
			.cur(cells[g]), .ins_here(ins[g]), .rem_here(rem[g])
		);
	end

	// slot tables
	assign wr_slot = (state_q == ST_EXEC) && (c_q.cmd == CMD_CREATE) && create_ok;
	always_ff @(posedge clk) begin
		if (wr_slot) begin
			task_m[free_slot] <= c_q.task_id;
			per_m[free_slot]  <= c_q.period;
			run_m[free_slot]  <= now_q;
		end
		if (state_q == ST_DUE && due_hit) begin
			run_m[head_s1.slot] <= now_q;
		end
		task_s1 <= task_m[cells[0].slot];
		per_s1  <= per_m[cells[0].slot];
		run_s1  <= run_m[cells[0].slot];
		head_s1 <= cells[0];
	end

	// sequencer: work out the next state and result word
	always_comb begin
		state_d     = state_q;
		c_d         = c_q;
		maxp_d      = maxp_q;
		now_d       = now_q;
		used_d      = used_q;
		cnt_d       = cnt_q;
		len_d       = len_q;
		res_valid_d = 1'b0;
		res_d       = '0;
		case (state_q)
			ST_IDLE: begin
				if (cfg_valid) maxp_d = cfg_data;
				if (start) begin
					c_d     = cmd;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				res_valid_d = (c_q.cmd != CMD_DISPATCH);
				res_d.last  = 1'b1;
				state_d     = ST_IDLE;
				case (c_q.cmd)
					CMD_CREATE: begin
						res_d.kind = KIND_CREATE;
						if (create_ok) begin
							res_d.ok     = 1'b1;
							res_d.handle = 4'(free_slot);
							used_d[free_slot] = 1'b1;
							len_d = len_q + LW'(1);
						end
					end
					CMD_DELETE: begin
						res_d.kind = KIND_DELETE;
						if (delete_ok) begin
							res_d.ok = 1'b1;
							used_d[c_q.slot[SW-1:0]] = 1'b0;
							if (rem_any) len_d = len_q - LW'(1);
						end
					end
					CMD_TICK: begin
						res_d.kind = KIND_TICK;
						now_d = now_q + 32'd1;
					end
					default: begin
						cnt_d   = LW'(SLOTS);
						state_d = ST_WALK;
					end
				endcase
			end
			ST_WALK: begin
				// latch the head, then rotate the row
				if (cnt_q != '0) cnt_d = cnt_q - LW'(1);
				state_d = ST_DUE;
			end
			ST_DUE: begin
				// report the latched head when it is due
				if (due_hit) begin
					res_valid_d          = 1'b1;
					res_d.kind           = KIND_DUE;
					res_d.handle         = 4'(head_s1.slot);
					res_d.due_task       = task_s1;
					res_d.elapsed_period = per_s1;
				end
				state_d = (cnt_q == '0) ? ST_END : ST_WALK;
			end
			ST_END: begin
				res_valid_d = 1'b1;
				res_d.kind  = KIND_END;
				res_d.last  = 1'b1;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			c_q       <= '0;
			maxp_q    <= 8'd31;
			now_q     <= '0;
			used_q    <= '0;
			cnt_q     <= '0;
			len_q     <= '0;
			res_valid <= 1'b0;
			res       <= '0;
		end else begin
			state_q   <= state_d;
			c_q       <= c_d;
			maxp_q    <= maxp_d;
			now_q     <= now_d;
			used_q    <= used_d;
			cnt_q     <= cnt_d;
			len_q     <= len_d;
			res_valid <= res_valid_d;
			res       <= res_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(SLOTS)) else $error("order length overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !res_valid || $past(state_q) != ST_IDLE)
		else $error("result with no work");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
endmodule
`default_nettype wire

FILE: rtl/ptd_cell.sv
`default_nettype none
module ptd_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ptd_pkg::cell_ctl_t ctl,
	input  wire ptd_pkg::entry_t  prev,
	input  wire ptd_pkg::entry_t  next,
	input  wire logic             prev_ins,
	output ptd_pkg::entry_t       cur,
	output logic                  ins_here,
	output logic                  rem_here
);
	import ptd_pkg::*;

	entry_t e_q;
	logic   prev_rem;
	logic   hit;

	assign cur = e_q;
	// insertion point: first entry of strictly greater priority, or first empty
	assign hit = !e_q.valid || (ctl.prio < e_q.prio);
	assign ins_here = prev_ins || hit;
	assign rem_here = e_q.valid && (e_q.slot == ctl.slot);

	// removal propagates from the matching cell downwards via prev_ins; prev_rem is tied low
	assign prev_rem = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= '0;
		end else if (ctl.rotate) begin
			// circulate the row by one place
			e_q <= next;
		end else begin
			case (ctl.op)
				OP_INSERT: begin
					if (hit && !prev_ins) begin
						e_q <= '{valid: 1'b1, slot: ctl.slot, prio: ctl.prio};
					end else if (prev_ins) begin
						e_q <= prev;
					end
				end
				OP_REMOVE: begin
					if (prev_ins || prev_rem) begin
						e_q <= next;
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: tb/periodic_task_dispatcher_chk.sv
`default_nettype none
module periodic_task_dispatcher_chk (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire ptd_pkg::cmd_word_t cmd,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic [7:0]         cfg_data,
	input  wire logic               res_valid,
	input  wire ptd_pkg::res_word_t res,
	output int                      errors,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ptd_pkg::*;

	// shadow copy of the scheduler state
	logic [31:0] now_ticks;
	logic        used [SLOTS];
	logic [7:0]  task_of [SLOTS];
	logic [15:0] period_of [SLOTS];
	logic [7:0]  prio_of [SLOTS];
	logic [31:0] ran_at [SLOTS];
	logic [3:0]  run_order [$];
	logic [7:0]  prio_limit;
	res_word_t   due_words [$];

	function automatic res_word_t mk_word(logic [2:0] kind, logic ok, logic [3:0] handle,
			logic [7:0] tid, logic [15:0] per, logic fin);
		res_word_t w;
		w.kind = kind;
		w.ok = ok;
		w.handle = handle;
		w.due_task = tid;
		w.elapsed_period = per;
		w.last = fin;
		return w;
	endfunction

	// work out the words a command word causes and update the shadow state
	task automatic schedule_step(cmd_word_t c);
		int s;
		int pos;
		logic ok_del;
		s = -1;
		pos = run_order.size();
		case (c.cmd)
			CMD_CREATE: begin
				if (c.task_id != 0 && c.period != 0 && c.priority_req <= prio_limit) begin
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!used[i]) s = i;
				end
				if (s < 0) begin
					due_words.push_back(mk_word(KIND_CREATE, 1'b0, 4'd0, 8'd0, 16'd0, 1'b1));
				end else begin
					used[s] = 1'b1;
					task_of[s] = c.task_id;
					period_of[s] = c.period;
					prio_of[s] = c.priority_req;
					ran_at[s] = now_ticks;
					for (int i = run_order.size() - 1; i >= 0; i--)
						if (c.priority_req < prio_of[run_order[i]]) pos = i;
					run_order.insert(pos, s[3:0]);
					due_words.push_back(mk_word(KIND_CREATE, 1'b1, s[3:0], 8'd0, 16'd0, 1'b1));
				end
			end
			CMD_DELETE: begin
				ok_del = used[c.slot];
				if (ok_del) begin
					used[c.slot] = 1'b0;
					for (int i = 0; i < run_order.size(); i++)
						if (run_order[i] == c.slot) pos = i;
					run_order.delete(pos);
				end
				due_words.push_back(mk_word(KIND_DELETE, ok_del, 4'd0, 8'd0, 16'd0, 1'b1));
			end
			CMD_TICK: begin
				now_ticks = now_ticks + 32'd1;
				due_words.push_back(mk_word(KIND_TICK, 1'b0, 4'd0, 8'd0, 16'd0, 1'b1));
			end
			default: begin
				foreach (run_order[i]) begin
					if (now_ticks - ran_at[run_order[i]] >= {16'd0, period_of[run_order[i]]}) begin
						ran_at[run_order[i]] = now_ticks;
						due_words.push_back(mk_word(KIND_DUE, 1'b0, run_order[i],
							task_of[run_order[i]], period_of[run_order[i]], 1'b0));
					end
				end
				due_words.push_back(mk_word(KIND_END, 1'b0, 4'd0, 8'd0, 16'd0, 1'b1));
			end
		endcase
	endtask

	assign pending = due_words.size();

	// compare the result word first, then take in new command and config words
	always @(posedge clk or negedge arst_n) begin
		res_word_t want;
		if (!arst_n) begin
			errors = 0;
			now_ticks = '0;
			prio_limit = 8'd31;
			run_order.delete();
			due_words.delete();
			for (int i = 0; i < SLOTS; i++) used[i] = 1'b0;
		end else begin
			if (res_valid) begin
				if (due_words.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result word %h", $realtime, res);
				end else begin
					want = due_words.pop_front();
					if (res !== want) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: kind %0d/%0d ok %0d/%0d handle %0d/%0d ",
								"task %0d/%0d period %0d/%0d last %0d/%0d (exp/got)"},
								$realtime, want.kind, res.kind, want.ok, res.ok,
								want.handle, res.handle, want.due_task, res.due_task,
								want.elapsed_period, res.elapsed_period, want.last, res.last);
					end
				end
			end
			if (start && !busy) schedule_step(cmd);
			if (cfg_valid && cfg_ready) prio_limit = cfg_data;
		end
	end
endmodule
`default_nettype wire

FILE: tb/periodic_task_dispatcher_tb.sv
`default_nettype none
module periodic_task_dispatcher_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ptd_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	cmd_word_t  cmd = '0;
	logic       cfg_valid = 1'b0;
	logic [7:0] cfg_data = '0;
	logic       busy, cfg_ready, res_valid;
	res_word_t  res;
	int         errors, pending;
	logic [7:0] prio_cap = 8'd31;
	int         sent [4] = '{0, 0, 0, 0};

	always #1 clk = ~clk;

	periodic_task_dispatcher dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.res_valid(res_valid), .res(res)
	);

	periodic_task_dispatcher_chk chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.res_valid(res_valid), .res(res), .errors(errors), .pending(pending)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// present one command word, hold it until the block takes it
	task automatic issue(cmd_word_t w, int gap);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= w;
		while (busy) @(negedge clk);
		@(posedge clk);
		sent[w.cmd]++;
	endtask

	function automatic cmd_word_t mk_cmd(logic [1:0] op, logic [7:0] tid, logic [15:0] per,
			logic [7:0] prio, logic [3:0] sl);
		cmd_word_t w;
		w.cmd = op;
		w.task_id = tid;
		w.period = per;
		w.priority_req = prio;
		w.slot = sl;
		return w;
	endfunction

	// drain all results, let the block settle, then write the priority limit
	task automatic set_limit(logic [7:0] v);
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SLOTS + 6) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		prio_cap = v;
	endtask

	function automatic cmd_word_t random_cmd();
		int r;
		logic [15:0] per;
		logic [7:0] prio;
		r = $urandom_range(0, 99);
		per = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
		if ($urandom_range(0, 29) == 0) per = 16'd0;
		prio = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, prio_cap));
		if (r < 35) return mk_cmd(CMD_CREATE, 8'($urandom), per, prio, 4'($urandom));
		if (r < 50) return mk_cmd(CMD_DELETE, 8'($urandom), 16'($urandom), 8'($urandom),
			4'($urandom));
		if (r < 80) return mk_cmd(CMD_TICK, 8'($urandom), 16'($urandom), 8'($urandom),
			4'($urandom));
		return mk_cmd(CMD_DISPATCH, 8'($urandom), 16'($urandom), 8'($urandom), 4'($urandom));
	endfunction

	initial begin
		#400000;
		$display("periodic_task_dispatcher_tb NOT OK");
		$finish;
	end

	initial begin
		logic [7:0] limits [4];
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: rejects, extremes, bad deletes, dispatch with and without due tasks
		issue(mk_cmd(CMD_CREATE, 8'd0, 16'd5, 8'd1, 4'd0), 0);
		issue(mk_cmd(CMD_CREATE, 8'd7, 16'd0, 8'd1, 4'd0), 0);
		issue(mk_cmd(CMD_CREATE, 8'd7, 16'd5, 8'd32, 4'd0), 0);
		issue(mk_cmd(CMD_CREATE, 8'd255, 16'hffff, 8'd31, 4'd0), 0);
		issue(mk_cmd(CMD_CREATE, 8'd1, 16'd1, 8'd0, 4'd0), 0);
		issue(mk_cmd(CMD_CREATE, 8'd2, 16'd1, 8'd0, 4'd0), 1);
		issue(mk_cmd(CMD_DISPATCH, 8'd0, 16'd0, 8'd0, 4'd0), 0);
		issue(mk_cmd(CMD_TICK, 8'd0, 16'd0, 8'd0, 4'd0), 0);
		issue(mk_cmd(CMD_DISPATCH, 8'd0, 16'd0, 8'd0, 4'd0), 0);
		issue(mk_cmd(CMD_DELETE, 8'd0, 16'd0, 8'd0, 4'd15), 0);
		issue(mk_cmd(CMD_DELETE, 8'd0, 16'd0, 8'd0, 4'd1), 0);
		issue(mk_cmd(CMD_DELETE, 8'd0, 16'd0, 8'd0, 4'd1), 0);
		for (int i = 0; i < 15; i++)
			issue(mk_cmd(CMD_CREATE, 8'(i + 10), 16'(i % 3 + 1), 8'($urandom_range(0, 31)),
				4'd0), 0);
		issue(mk_cmd(CMD_TICK, 8'd0, 16'd0, 8'd0, 4'd0), 0);
		issue(mk_cmd(CMD_DISPATCH, 8'd0, 16'd0, 8'd0, 4'd0), 0);

		// random phases over several priority limits, extremes among them
		limits = '{8'd0, 8'd255, 8'($urandom_range(1, 254)), 8'd31};
		foreach (limits[p]) begin
			set_limit(limits[p]);
			for (int k = 0; k < 65; k++) begin
				issue(random_cmd(), ($urandom_range(0, 3) == 0) ? 0 : pick_gap());
				if (k == 32) begin
					@(negedge clk);
					start <= 1'b0;
					while (pending != 0) @(negedge clk);
				end
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SLOTS + 10) @(negedge clk);
		$display("Covered %0d creates, %0d deletes, %0d ticks, %0d dispatches",
			sent[CMD_CREATE], sent[CMD_DELETE], sent[CMD_TICK], sent[CMD_DISPATCH]);
		$display("over priority limits 31, 0, 255, one random value and 31 again.");
		if (errors == 0)
			$display("periodic_task_dispatcher_tb OK");
		else
			$display("periodic_task_dispatcher_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
